@@ rtl/core/date_time_field_editor_macros.svh @@
// Assertion macros for the date and time field editor.
// Used by the RTL files under rtl/core; relies on signals named clk and rst.
`ifndef DATE_TIME_FIELD_EDITOR_MACROS_SVH
`define DATE_TIME_FIELD_EDITOR_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define DTFE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define DTFE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/dtfe_pkg.sv @@
// Shared types, codes and calendar helpers for the date and time field editor.
// No dependencies; imported by dtfe_next and date_time_field_editor.
`default_nettype none

package dtfe_pkg;

  // Field widths.
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int FIELD_W = 3;
  localparam int CMD_W   = 3;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_LOAD = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PREV = 3'd1;
  localparam logic [CMD_W-1:0] CMD_NEXT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_INC  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DEC  = 3'd4;

  // Field selection codes.
  localparam logic [FIELD_W-1:0] FIELD_YEAR   = 3'd0;
  localparam logic [FIELD_W-1:0] FIELD_MONTH  = 3'd1;
  localparam logic [FIELD_W-1:0] FIELD_DAY    = 3'd2;
  localparam logic [FIELD_W-1:0] FIELD_HOUR   = 3'd3;
  localparam logic [FIELD_W-1:0] FIELD_MINUTE = 3'd4;

  // Calendar limits and defaults.
  localparam logic [YEAR_W-1:0]  YEAR_MIN       = 14'd2000;
  localparam logic [YEAR_W-1:0]  YEAR_MAX       = 14'd2099;
  localparam logic [YEAR_W-1:0]  YEAR_BELOW_MIN = YEAR_MIN - 14'd1;
  localparam logic [YEAR_W-1:0]  YEAR_ABOVE_MAX = YEAR_MAX + 14'd1;
  localparam logic [MONTH_W-1:0] MONTH_DEFAULT  = 4'd1;
  localparam logic [MONTH_W-1:0] MONTHS         = 4'd12;
  localparam logic [MONTH_W-1:0] MONTH_FEB      = 4'd2;
  localparam logic [DAY_W-1:0]   DAY_DEFAULT    = 5'd1;
  localparam logic [DAY_W-1:0]   DAYS_LONG      = 5'd31;
  localparam logic [DAY_W-1:0]   DAYS_FEB_LEAP  = 5'd29;
  localparam logic [DAY_W-1:0]   DAYS_FEB       = 5'd28;
  localparam logic [5:0]         HOURS          = 6'd24;
  localparam logic [6:0]         MINUTES        = 7'd60;

  // Month lengths, January first.
  localparam logic [DAY_W-1:0] MONTH_DAYS [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Divisibility by 25 on a 14-bit year: multiply by the inverse of 25
  // modulo 2^14; multiples of 25 land exactly in 0..floor((2^14-1)/25).
  localparam logic [YEAR_W-1:0] INV25       = 14'd7209;
  localparam logic [YEAR_W-1:0] DIV25_LIMIT = 14'd655;

  // Complete editor state.
  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [FIELD_W-1:0] field;
  } dtfe_state_t;

  // Gregorian leap year test for any 14-bit year.
  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [YEAR_W-1:0] prod;
    logic              div25;
    prod  = YEAR_W'(y * INV25);
    div25 = (prod <= DIV25_LIMIT);
    return ((y[1:0] == 2'b00) && !div25) || ((y[3:0] == 4'b0000) && div25);
  endfunction

  // Month length; a month outside 1..12 counts as 31 days.
  function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                 input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    if (m == MONTH_FEB) begin
      len = leap ? DAYS_FEB_LEAP : DAYS_FEB;
    end else if (m >= MONTH_DEFAULT && m <= MONTHS) begin
      len = MONTH_DAYS[m - MONTH_DEFAULT];
    end else begin
      len = DAYS_LONG;
    end
    return len;
  endfunction

  // Clamp a day into 1..month length.
  function automatic logic [DAY_W-1:0] clamp_day(input logic [DAY_W-1:0] d,
                                                 input logic [DAY_W-1:0] mx);
    logic [DAY_W-1:0] r;
    if (d == '0) begin
      r = DAY_DEFAULT;
    end else if (d > mx) begin
      r = mx;
    end else begin
      r = d;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/date_time_field_editor.sv @@
// Top level of the date and time field editor: state register and result handshake.
// Depends on dtfe_pkg, dtfe_next and date_time_field_editor_macros.svh.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------------------
//   input   | in        | in_valid / in_ready  | cmd, load_valid, load_year..load_minute
//   result  | out       | out_valid / out_ready| year_out..minute_out, field_out
//
// Each command is applied in the cycle it is accepted; its result is shown
// the next cycle. One command per cycle is sustained while out_ready is high.
// The editor state register doubles as the result register, so a result
// stalled by out_ready low holds off the next input beat.
// Reset sets 2000-01-01 00:00 with the year field selected and no result pending.
`default_nettype none

`include "date_time_field_editor_macros.svh"

module date_time_field_editor (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [dtfe_pkg::CMD_W-1:0]   cmd,
  input  logic                         load_valid,
  input  logic [dtfe_pkg::YEAR_W-1:0]  load_year,
  input  logic [dtfe_pkg::MONTH_W-1:0] load_month,
  input  logic [dtfe_pkg::DAY_W-1:0]   load_day,
  input  logic [dtfe_pkg::HOUR_W-1:0]  load_hour,
  input  logic [dtfe_pkg::MIN_W-1:0]   load_minute,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [dtfe_pkg::YEAR_W-1:0]  year_out,
  output logic [dtfe_pkg::MONTH_W-1:0] month_out,
  output logic [dtfe_pkg::DAY_W-1:0]   day_out,
  output logic [dtfe_pkg::HOUR_W-1:0]  hour_out,
  output logic [dtfe_pkg::MIN_W-1:0]   minute_out,
  output logic [dtfe_pkg::FIELD_W-1:0] field_out
);

  import dtfe_pkg::*;

  dtfe_state_t cur;
  dtfe_state_t cur_next;
  logic        in_fire;
  logic        out_stall;
  logic        load_fire;
  logic        year_step;
  logic        year_ok;

  // A new beat is taken whenever the result slot is empty or being drained.
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  dtfe_next u_next (
    .cur         (cur),
    .cmd         (cmd),
    .load_valid  (load_valid),
    .load_year   (load_year),
    .load_month  (load_month),
    .load_day    (load_day),
    .load_hour   (load_hour),
    .load_minute (load_minute),
    .nxt         (cur_next)
  );

  // Editor state and result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur.year   <= YEAR_MIN;
      cur.month  <= MONTH_DEFAULT;
      cur.day    <= DAY_DEFAULT;
      cur.hour   <= '0;
      cur.minute <= '0;
      cur.field  <= FIELD_YEAR;
      out_valid  <= 1'b0;
    end else if (in_fire) begin
      cur       <= cur_next;
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // The result fields show the state after the last accepted command.
  assign year_out   = cur.year;
  assign month_out  = cur.month;
  assign day_out    = cur.day;
  assign hour_out   = cur.hour;
  assign minute_out = cur.minute;
  assign field_out  = cur.field;

  // Checks on the state and the handshake coupling.
  assign out_stall = out_valid && !out_ready;
  assign load_fire = in_fire && (cmd == CMD_LOAD);
  assign year_step = in_fire && (cmd == CMD_INC || cmd == CMD_DEC) && (cur.field == FIELD_YEAR);
  assign year_ok   = (cur.year >= YEAR_MIN) && (cur.year <= YEAR_MAX);

  `DTFE_ASSERT_NXT(a_fire_gives_result, in_fire, out_valid, "accepted beat gave no result")
  `DTFE_ASSERT_IMP(a_stall_blocks_input, out_stall, !in_ready, "input taken while stalled")
  `DTFE_ASSERT_IMP(a_day_nonzero, 1'b1, cur.day != '0, "day register holds zero")
  `DTFE_ASSERT_NXT(a_load_selects_year, load_fire, cur.field == FIELD_YEAR, "year not selected")
  `DTFE_ASSERT_NXT(a_year_saturates, year_step, year_ok, "year step left range")

endmodule

`default_nettype wire

@@ rtl/core/dtfe_next.sv @@
// Next-state logic of the date and time field editor for one command.
// Depends on dtfe_pkg (state struct, codes, calendar helpers).
`default_nettype none

module dtfe_next (
  input  dtfe_pkg::dtfe_state_t        cur,
  input  logic [dtfe_pkg::CMD_W-1:0]   cmd,
  input  logic                         load_valid,
  input  logic [dtfe_pkg::YEAR_W-1:0]  load_year,
  input  logic [dtfe_pkg::MONTH_W-1:0] load_month,
  input  logic [dtfe_pkg::DAY_W-1:0]   load_day,
  input  logic [dtfe_pkg::HOUR_W-1:0]  load_hour,
  input  logic [dtfe_pkg::MIN_W-1:0]   load_minute,
  output dtfe_pkg::dtfe_state_t        nxt
);

  import dtfe_pkg::*;

  logic                up;
  logic [DAY_W-1:0]    len_cur;
  logic [DAY_W-1:0]    len_load;
  logic [YEAR_W-1:0]   year_inc;
  logic [YEAR_W-1:0]   year_dec;
  logic [YEAR_W-1:0]   year_adj;
  logic [DAY_W-1:0]    len_year_adj;
  logic [4:0]          month_sum;
  logic [MONTH_W-1:0]  month_adj;
  logic [DAY_W-1:0]    len_month_adj;
  logic [DAY_W-1:0]    day_adj;
  logic [5:0]          hour_sum;
  logic [HOUR_W-1:0]   hour_adj;
  logic [6:0]          minute_sum;
  logic [MIN_W-1:0]    minute_adj;
  logic [FIELD_W-1:0]  field_prev;
  logic [FIELD_W-1:0]  field_next;

  assign up = (cmd == CMD_INC);

  // Month lengths for the stored year and month and for the load value.
  assign len_cur  = month_len(is_leap(cur.year), cur.month);
  assign len_load = month_len(is_leap(load_year), load_month);

  // Year step with saturation into 2000..2099. The result stays in that
  // range, where every year divisible by four is a leap year.
  assign year_inc = (cur.year < YEAR_BELOW_MIN) ? YEAR_MIN :
                    (cur.year >= YEAR_MAX)      ? YEAR_MAX : cur.year + 14'd1;
  assign year_dec = (cur.year <= YEAR_MIN)      ? YEAR_MIN :
                    (cur.year > YEAR_ABOVE_MAX) ? YEAR_MAX : cur.year - 14'd1;
  assign year_adj     = up ? year_inc : year_dec;
  assign len_year_adj = month_len(year_adj[1:0] == 2'b00, cur.month);

  // Month step with wrap over twelve; the sum stays below 24 + 12.
  always_comb begin
    month_sum = up ? {1'b0, cur.month} : {1'b0, cur.month} + 5'd10;
    if (month_sum >= {MONTHS, 1'b0}) begin
      month_sum = month_sum - {MONTHS, 1'b0};
    end else if (month_sum >= {1'b0, MONTHS}) begin
      month_sum = month_sum - {1'b0, MONTHS};
    end
    month_adj = MONTH_W'(month_sum) + MONTH_DEFAULT;
  end
  assign len_month_adj = month_len(is_leap(cur.year), month_adj);

  // Day step with wrap at the current month length.
  always_comb begin
    if (up) begin
      day_adj = (cur.day >= len_cur) ? DAY_DEFAULT : cur.day + 5'd1;
    end else begin
      day_adj = (cur.day <= DAY_DEFAULT) ? len_cur : cur.day - 5'd1;
    end
  end

  // Hour and minute steps with wrap; each sum needs at most one subtraction.
  always_comb begin
    hour_sum = up ? {1'b0, cur.hour} + 6'd1 : {1'b0, cur.hour} + 6'd23;
    if (hour_sum >= {HOURS[4:0], 1'b0}) begin
      hour_sum = hour_sum - {HOURS[4:0], 1'b0};
    end else if (hour_sum >= HOURS) begin
      hour_sum = hour_sum - HOURS;
    end
    hour_adj = HOUR_W'(hour_sum);

    minute_sum = up ? {1'b0, cur.minute} + 7'd1 : {1'b0, cur.minute} + 7'd59;
    if (minute_sum >= {MINUTES[5:0], 1'b0}) begin
      minute_sum = minute_sum - {MINUTES[5:0], 1'b0};
    end else if (minute_sum >= MINUTES) begin
      minute_sum = minute_sum - MINUTES;
    end
    minute_adj = MIN_W'(minute_sum);
  end

  // Field selection moves with wrap over five fields.
  assign field_prev = (cur.field == FIELD_YEAR)   ? FIELD_MINUTE : cur.field - 3'd1;
  assign field_next = (cur.field == FIELD_MINUTE) ? FIELD_YEAR   : cur.field + 3'd1;

  // Command decode.
  always_comb begin
    nxt = cur;
    unique case (cmd) inside
      CMD_LOAD: begin
        if (load_valid) begin
          nxt.year   = load_year;
          nxt.month  = load_month;
          nxt.day    = clamp_day(load_day, len_load);
          nxt.hour   = load_hour;
          nxt.minute = load_minute;
        end else begin
          nxt.year   = YEAR_MIN;
          nxt.month  = MONTH_DEFAULT;
          nxt.day    = DAY_DEFAULT;
          nxt.hour   = '0;
          nxt.minute = '0;
        end
        nxt.field = FIELD_YEAR;
      end
      CMD_PREV: nxt.field = field_prev;
      CMD_NEXT: nxt.field = field_next;
      CMD_INC, CMD_DEC: begin
        case (cur.field)
          FIELD_YEAR: begin
            nxt.year = year_adj;
            nxt.day  = clamp_day(cur.day, len_year_adj);
          end
          FIELD_MONTH: begin
            nxt.month = month_adj;
            nxt.day   = clamp_day(cur.day, len_month_adj);
          end
          FIELD_DAY:    nxt.day    = day_adj;
          FIELD_HOUR:   nxt.hour   = hour_adj;
          FIELD_MINUTE: nxt.minute = minute_adj;
          default:      nxt = cur;
        endcase
      end
      default: nxt = cur;
    endcase
  end

endmodule

`default_nettype wire

@@ tb/sv/date_time_field_editor_tb.sv @@
// Self-checking testbench for the date and time field editor.
// Needs dtfe_pkg and date_time_field_editor; a scoreboard class keeps its own
// calendar state and checks every result beat against it.
`default_nettype none

module date_time_field_editor_tb;
  import dtfe_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 9;
  localparam int RANDOM_ITEMS = 850;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int TAIL_CYCLES  = 8;

  // Command codes the block does not define; they must leave the state alone.
  localparam logic [CMD_W-1:0] CMD_UNKNOWN_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNKNOWN_HI = 3'd7;

  // One command beat as the sender presents it.
  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic               use_given;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
  } command_t;

  // Tracks the editor's calendar and the results still owed by the block.
  class dtfe_scoreboard;
    dtfe_state_t cal;
    dtfe_state_t owed_values[$];
    int          mismatches;

    function new();
      cal        = '{year: YEAR_MIN, month: MONTH_DEFAULT, day: DAY_DEFAULT,
                     hour: '0, minute: '0, field: FIELD_YEAR};
      mismatches = 0;
    endfunction

    // Gregorian month length; months outside 1..12 count as 31 days.
    function int month_days(int y, int m);
      bit leap;
      leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      if (m < 1 || m > 12) return 31;
      if (m == 2) return leap ? 29 : 28;
      return int'(MONTH_DAYS[m - 1]);
    endfunction

    function void clamp_to_month();
      int mx;
      mx = month_days(int'(cal.year), int'(cal.month));
      if (cal.day == '0) cal.day = DAY_DEFAULT;
      if (int'(cal.day) > mx) cal.day = DAY_W'(mx);
    endfunction

    // Increment or decrement the selected field.
    function void step_field(bit up);
      int v;
      int mx;
      case (cal.field)
        FIELD_YEAR: begin
          v = int'(cal.year) + (up ? 1 : -1);
          if (v < int'(YEAR_MIN)) v = int'(YEAR_MIN);
          if (v > int'(YEAR_MAX)) v = int'(YEAR_MAX);
          cal.year = YEAR_W'(v);
          clamp_to_month();
        end
        FIELD_MONTH: begin
          cal.month = MONTH_W'((int'(cal.month) + (up ? 12 : 10)) % 12 + 1);
          clamp_to_month();
        end
        FIELD_DAY: begin
          mx      = month_days(int'(cal.year), int'(cal.month));
          v       = int'(cal.day) - 1 + mx + (up ? 1 : -1);
          cal.day = DAY_W'(v % mx + 1);
        end
        FIELD_HOUR:   cal.hour   = HOUR_W'((int'(cal.hour) + (up ? 25 : 23)) % 24);
        FIELD_MINUTE: cal.minute = MIN_W'((int'(cal.minute) + (up ? 61 : 59)) % 60);
        default: ;
      endcase
    endfunction

    // Apply an accepted command and queue the value the block must return.
    function void note_command(command_t c);
      case (c.cmd)
        CMD_LOAD: begin
          if (c.use_given) begin
            cal.year   = c.year;
            cal.month  = c.month;
            cal.day    = c.day;
            cal.hour   = c.hour;
            cal.minute = c.minute;
          end else begin
            cal.year   = YEAR_MIN;
            cal.month  = MONTH_DEFAULT;
            cal.day    = DAY_DEFAULT;
            cal.hour   = '0;
            cal.minute = '0;
          end
          clamp_to_month();
          cal.field = FIELD_YEAR;
        end
        CMD_PREV: cal.field = FIELD_W'((int'(cal.field) + 4) % 5);
        CMD_NEXT: cal.field = FIELD_W'((int'(cal.field) + 1) % 5);
        CMD_INC:  step_field(1'b1);
        CMD_DEC:  step_field(1'b0);
        default: ;
      endcase
      owed_values.push_back(cal);
    endfunction

    // Compare a result beat with the oldest owed value.
    function void check_result(dtfe_state_t got);
      dtfe_state_t want;
      if (owed_values.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat %0d-%0d-%0d %0d:%0d field %0d",
                   got.year, got.month, got.day, got.hour, got.minute, got.field);
        return;
      end
      want = owed_values.pop_front();
      if (got.year !== want.year || got.month !== want.month || got.day !== want.day ||
          got.hour !== want.hour || got.minute !== want.minute ||
          got.field !== want.field) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %0d-%0d-%0d %0d:%0d field %0d,",
                   want.year, want.month, want.day, want.hour, want.minute, want.field,
                   " got %0d-%0d-%0d %0d:%0d field %0d",
                   got.year, got.month, got.day, got.hour, got.minute, got.field);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [CMD_W-1:0]   cmd = CMD_LOAD;
  logic               load_valid = 1'b0;
  logic [YEAR_W-1:0]  load_year = '0;
  logic [MONTH_W-1:0] load_month = '0;
  logic [DAY_W-1:0]   load_day = '0;
  logic [HOUR_W-1:0]  load_hour = '0;
  logic [MIN_W-1:0]   load_minute = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [YEAR_W-1:0]  year_out;
  logic [MONTH_W-1:0] month_out;
  logic [DAY_W-1:0]   day_out;
  logic [HOUR_W-1:0]  hour_out;
  logic [MIN_W-1:0]   minute_out;
  logic [FIELD_W-1:0] field_out;

  int             cycle_count = 0;
  dtfe_scoreboard sb = new();

  date_time_field_editor u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .load_valid (load_valid),
    .load_year  (load_year),
    .load_month (load_month),
    .load_day   (load_day),
    .load_hour  (load_hour),
    .load_minute(load_minute),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .year_out   (year_out),
    .month_out  (month_out),
    .day_out    (day_out),
    .hour_out   (hour_out),
    .minute_out (minute_out),
    .field_out  (field_out)
  );

  always #CLK_HALF clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Monitor: the result beat is checked before the command beat of the same
  // edge is noted, since that command's result can only come later.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        sb.check_result('{year: year_out, month: month_out, day: day_out,
                          hour: hour_out, minute: minute_out, field: field_out});
      if (in_valid && in_ready)
        sb.note_command('{cmd: cmd, use_given: load_valid, year: load_year,
                          month: load_month, day: load_day, hour: load_hour,
                          minute: load_minute});
    end
  end

  // Receiver stall pattern: stretches of always ready, coin flips,
  // three of four, and mostly stalled.
  initial begin
    int mode;
    int span;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(5, 60);
      for (int k = 0; k < span; k++) begin
        @(posedge clk);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= (k % 4 != 3);
          default: out_ready <= (k % 7 == 0);
        endcase
      end
    end
  end

  function automatic command_t make_cmd(logic [CMD_W-1:0] op, logic given, int y, int m,
                                        int d, int h, int mi);
    command_t c;
    c = '{cmd: op, use_given: given, year: YEAR_W'(y), month: MONTH_W'(m),
          day: DAY_W'(d), hour: HOUR_W'(h), minute: MIN_W'(mi)};
    return c;
  endfunction

  // Mostly editing keys, some loads (plausible or raw), a few unknown codes.
  function automatic command_t random_command();
    command_t c;
    int       pick;
    c.cmd       = CMD_LOAD;
    c.use_given = 1'($urandom);
    c.year      = YEAR_W'($urandom);
    c.month     = MONTH_W'($urandom);
    c.day       = DAY_W'($urandom);
    c.hour      = HOUR_W'($urandom);
    c.minute    = MIN_W'($urandom);
    pick        = $urandom_range(0, 99);
    if (pick < 9) begin
      c.use_given = (pick != 0);
      if ($urandom_range(0, 3) != 0) begin
        c.year   = YEAR_W'($urandom_range(1996, 2103));
        c.month  = MONTH_W'($urandom_range(1, 12));
        c.day    = DAY_W'($urandom_range(0, 31));
        c.hour   = HOUR_W'($urandom_range(0, 23));
        c.minute = MIN_W'($urandom_range(0, 59));
      end
    end else if (pick < 20) begin
      c.cmd = CMD_PREV;
    end else if (pick < 38) begin
      c.cmd = CMD_NEXT;
    end else if (pick < 68) begin
      c.cmd = CMD_INC;
    end else if (pick < 95) begin
      c.cmd = CMD_DEC;
    end else begin
      c.cmd = CMD_W'($urandom_range(int'(CMD_UNKNOWN_LO), int'(CMD_UNKNOWN_HI)));
    end
    return c;
  endfunction

  // Present one command beat and hold it until accepted.
  task automatic send_beat(input command_t c);
    in_valid    <= 1'b1;
    cmd         <= c.cmd;
    load_valid  <= c.use_given;
    load_year   <= c.year;
    load_month  <= c.month;
    load_day    <= c.day;
    load_hour   <= c.hour;
    load_minute <= c.minute;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid and wait until every owed result has been taken.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.owed_values.size() != 0) @(posedge clk);
  endtask

  initial begin
    command_t directed[$];
    int       sent;
    int       burst;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: default load, wraps, leap rules, raw loads and saturation.
    directed.push_back(make_cmd(CMD_LOAD, 1'b0, 16383, 15, 31, 31, 63));
    directed.push_back(make_cmd(CMD_PREV, 1'b0, 0, 0, 0, 0, 0));
    directed.push_back(make_cmd(CMD_DEC, 1'b0, 0, 0, 0, 0, 0));
    directed.push_back(make_cmd(CMD_NEXT, 1'b0, 0, 0, 0, 0, 0));
    directed.push_back(make_cmd(CMD_LOAD, 1'b1, 2024, 2, 31, 23, 59));
    directed.push_back(make_cmd(CMD_INC, 1'b1, 0, 0, 0, 0, 0));
    directed.push_back(make_cmd(CMD_LOAD, 1'b1, 2100, 2, 29, 12, 30));
    directed.push_back(make_cmd(CMD_LOAD, 1'b1, 2000, 2, 30, 0, 0));
    directed.push_back(make_cmd(CMD_LOAD, 1'b1, 16383, 15, 31, 31, 63));
    directed.push_back(make_cmd(CMD_INC, 1'b0, 0, 0, 0, 0, 0));
    directed.push_back(make_cmd(CMD_NEXT, 1'b0, 0, 0, 0, 0, 0));
    directed.push_back(make_cmd(CMD_INC, 1'b0, 0, 0, 0, 0, 0));
    directed.push_back(make_cmd(CMD_LOAD, 1'b1, 5, 0, 0, 31, 63));
    directed.push_back(make_cmd(CMD_DEC, 1'b0, 0, 0, 0, 0, 0));
    directed.push_back(make_cmd(CMD_NEXT, 1'b0, 0, 0, 0, 0, 0));
    directed.push_back(make_cmd(CMD_DEC, 1'b0, 0, 0, 0, 0, 0));
    directed.push_back(make_cmd(CMD_NEXT, 1'b0, 0, 0, 0, 0, 0));
    directed.push_back(make_cmd(CMD_DEC, 1'b0, 0, 0, 0, 0, 0));
    directed.push_back(make_cmd(CMD_INC, 1'b0, 0, 0, 0, 0, 0));
    directed.push_back(make_cmd(CMD_NEXT, 1'b0, 0, 0, 0, 0, 0));
    directed.push_back(make_cmd(CMD_INC, 1'b0, 0, 0, 0, 0, 0));
    directed.push_back(make_cmd(CMD_NEXT, 1'b0, 0, 0, 0, 0, 0));
    directed.push_back(make_cmd(CMD_DEC, 1'b0, 0, 0, 0, 0, 0));
    directed.push_back(make_cmd(CMD_UNKNOWN_LO, 1'b1, 0, 0, 0, 0, 0));
    directed.push_back(make_cmd(CMD_UNKNOWN_HI, 1'b0, 0, 0, 0, 0, 0));
    foreach (directed[i]) send_beat(directed[i]);

    // Let the directed part drain completely before random traffic.
    wait_for_results();

    // Random traffic in bursts, with an occasional full drain.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
        send_beat(random_command());
        sent++;
      end
      if ($urandom_range(0, 15) == 0) begin
        wait_for_results();
      end else begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.owed_values.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
